// ----- hw/rtl/isa_pkg.sv -----
// Shared widths, register codes and constants of the IMU static alignment block.
// Used by isa_div_lane and imu_static_alignment; depends on nothing else.
package isa_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned NUM_CH    = 7;
    localparam int unsigned THR_W     = 31;
    localparam int unsigned CFG_IDX_W = 2;

    // Serial divider: numerator magnitude, divisor magnitude, iteration count width.
    localparam int unsigned DIV_NUM_W = 64;
    localparam int unsigned DIV_DEN_W = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_THR   = 2'd2;

    localparam logic [THR_W-1:0] GYRO_THR_RST  = 31'd1966;
    localparam logic [THR_W-1:0] ACCEL_THR_RST = 31'd1966;
    localparam logic [THR_W-1:0] YAW_THR_RST   = 31'd655;

    localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
    localparam logic [32:0] GRAV_Q16  = 33'd642689;
    localparam logic [32:0] GRAV2_Q16 = 33'd1285378;

endpackage

// ----- hw/rtl/isa_div_lane.sv -----
// Bit-serial restoring divider lane: unsigned magnitude quotient, one bit per cycle.
// Depends on isa_pkg for its widths.
module isa_div_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [isa_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [isa_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_busy,
    output logic [isa_pkg::DIV_NUM_W-1:0] o_quo
);

    logic                          r_busy;
    logic [isa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [isa_pkg::DIV_DEN_W-1:0] r_den;
    logic [isa_pkg::DIV_DEN_W-1:0] r_rem;
    logic [isa_pkg::DIV_NUM_W-1:0] r_num;
    logic [isa_pkg::DIV_DEN_W:0]   w_rem_sh;
    logic [isa_pkg::DIV_DEN_W:0]   w_diff;
    logic                          w_ge;

    assign w_rem_sh = {r_rem, r_num[isa_pkg::DIV_NUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= isa_pkg::DIV_CNT_W'(isa_pkg::DIV_NUM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Quotient bits shift in at the bottom as the numerator bits leave the top.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[isa_pkg::DIV_DEN_W-1:0] : w_rem_sh[isa_pkg::DIV_DEN_W-1:0];
            r_num <= {r_num[isa_pkg::DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;

endmodule

// ----- hw/rtl/imu_static_alignment.sv -----
// IMU static alignment: motion detection on running means, leveling and bias solve.
// Depends on isa_pkg and isa_div_lane.
//
// Usage: one IMU sample per request on the s_axis channel (seven Q16.16 words),
// one result per sample on the m_axis channel. tuser carries the moving flag;
// tdata carries the quaternion (Q2.30) and the six biases (Q16.16), all zero
// until motion has been seen. Thresholds are written on the cfg channel, which
// is always ready, while the block is idle; the user must keep to this, as the
// block itself does not enforce it. Before motion a sample passes an accept
// state, a load state, a wait on the mean computation in seven bit-serial
// divider lanes running side by side, a compare state and an output state. The
// first motion adds a one-time solve on a shared bit-serial multiplier,
// square-root unit and divider lane 0. After that the block latches and each
// sample is answered with held results.
// One sample is in work at a time; a new sample is taken while the previous
// result still sits in the output register. If the receiver stalls, a finished
// result waits until the output register frees. Reset clears sums, count,
// latch and held results and restores the default thresholds.
module imu_static_alignment #(
    parameter int unsigned MAX_SAMPLES = 65535
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, heading (32 bits each)
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, bias_gyro_x/y/z, bias_accel_x/y/z (32 bits each)
    output logic [319:0] m_axis_tdata,
    // moving
    output logic         m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [isa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [isa_pkg::THR_W-1:0]     i_cfg_data
);

    localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W  = isa_pkg::DATA_W + CNT_W;
    localparam int unsigned ITER_W = 5;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_DIV, S_CHECK, S_OP_START, S_OP_WAIT, S_OP_DONE, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        ST_SQ_AX, ST_SQ_AY, ST_SQ_AZ, ST_N1, ST_N, ST_CR, ST_CP,
        ST_CHR, ST_SHR, ST_CHP, ST_SHP, ST_W, ST_X, ST_Y, ST_Z,
        ST_XZ, ST_WY, ST_YZ, ST_WX, ST_WW, ST_XX, ST_YY, ST_ZZ,
        ST_GX, ST_GY, ST_GZ, ST_FINAL
    } t_step;

    typedef enum logic [1:0] {K_MUL, K_SQRT, K_DIV} t_kind;

    function automatic logic [34:0] sx35(input logic [31:0] v);
        return {{3{v[31]}}, v};
    endfunction

    function automatic logic [32:0] sx33(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic [31:0] sat32(input logic [32:0] v);
        logic [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Control and held state.
    t_state                     r_state;
    t_step                      r_step;
    logic [ITER_W-1:0]          r_cnt;
    logic                       r_latched;
    logic [SUM_W-1:0]           r_sum [isa_pkg::NUM_CH];
    logic [CNT_W-1:0]           r_count;
    logic [3:0][31:0]           r_hq;
    logic [5:0][31:0]           r_hb;
    logic                       r_m_valid;
    logic [isa_pkg::THR_W-1:0]  r_thr [3];

    // Datapath.
    logic [31:0]                r_v    [isa_pkg::NUM_CH];
    logic [31:0]                r_mean [isa_pkg::NUM_CH];
    logic [319:0]               r_m_data;
    logic                       r_m_user;
    logic [34:0]                r_mul_a;
    logic [66:0]                r_prod;
    logic                       r_mul_neg;
    logic [63:0]                r_sq_in;
    logic [33:0]                r_sq_rem;
    logic [31:0]                r_sq_root;
    logic [63:0]                r_sq [3];
    logic [31:0]                r_n1, r_n, r_cr, r_cp;
    logic [31:0]                r_chr, r_shr, r_chp, r_shp;
    logic [31:0]                r_q  [4];
    logic [31:0]                r_pp [8];
    logic [31:0]                r_g  [3];

    logic                       w_accept;
    logic                       w_out_load;
    logic                       w_op_go;
    logic                       w_cnt_room;
    logic [isa_pkg::NUM_CH-1:0] w_lane_start;
    logic [isa_pkg::NUM_CH-1:0] w_lane_busy;
    logic [63:0]                w_lane_num [isa_pkg::NUM_CH];
    logic [31:0]                w_lane_den [isa_pkg::NUM_CH];
    logic [63:0]                w_lane_quo [isa_pkg::NUM_CH];
    logic [31:0]                w_mean     [isa_pkg::NUM_CH];
    logic [isa_pkg::NUM_CH-1:0] w_exceed;
    logic                       w_moving;

    t_kind                      w_kind;
    logic [34:0]                w_op_a;
    logic [32:0]                w_op_b;
    logic [34:0]                w_a_mag;
    logic [32:0]                w_b_mag;
    logic [63:0]                w_sq_in;
    logic [63:0]                w_dv_num;
    logic [31:0]                w_dv_den;
    logic [31:0]                w_az_mag;
    logic [31:0]                w_ha_c;
    logic [32:0]                w_ha_p, w_ha_m;
    logic [35:0]                w_mul_tmp;
    logic [36:0]                w_mq;
    logic [35:0]                w_rt_sh, w_rt_trial, w_rt_diff;
    logic                       w_rt_ge;
    logic [31:0]                w_dq;

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_out_load   = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);
    assign w_op_go      = (r_state == S_OP_START) && (r_step != ST_FINAL);
    assign w_cnt_room   = r_count < CNT_W'(MAX_SAMPLES);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign o_cfg_ready   = 1'b1;

    // ---------------- mean lanes ----------------
    for (genvar gi = 0; gi < isa_pkg::NUM_CH; gi++) begin : g_lane
        logic [SUM_W-1:0] w_sum_mag;
        logic [31:0]      w_q;
        logic [32:0]      w_diff;
        logic [32:0]      w_dmag;
        logic [isa_pkg::THR_W-1:0] w_lim;

        assign w_sum_mag = r_sum[gi][SUM_W-1] ? -r_sum[gi] : r_sum[gi];
        if (gi == 0) begin : g_shared
            assign w_lane_num[gi]   = (r_state == S_LOAD) ? 64'(w_sum_mag) : w_dv_num;
            assign w_lane_den[gi]   = (r_state == S_LOAD) ? 32'(r_count) : w_dv_den;
            assign w_lane_start[gi] = (r_state == S_LOAD) || (w_op_go && (w_kind == K_DIV));
        end else begin : g_plain
            assign w_lane_num[gi]   = 64'(w_sum_mag);
            assign w_lane_den[gi]   = 32'(r_count);
            assign w_lane_start[gi] = (r_state == S_LOAD);
        end

        isa_div_lane u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_lane_start[gi]),
            .i_num   (w_lane_num[gi]),
            .i_den   (w_lane_den[gi]),
            .o_busy  (w_lane_busy[gi]),
            .o_quo   (w_lane_quo[gi])
        );

        assign w_q          = w_lane_quo[gi][31:0];
        assign w_mean[gi]   = r_sum[gi][SUM_W-1] ? -w_q : w_q;
        assign w_diff       = sx33(r_v[gi]) - sx33(w_mean[gi]);
        assign w_dmag       = w_diff[32] ? -w_diff : w_diff;
        assign w_lim        = (gi < 3) ? r_thr[0] : ((gi < 6) ? r_thr[1] : r_thr[2]);
        assign w_exceed[gi] = w_dmag > {2'b0, w_lim};
    end

    assign w_moving = (r_count > CNT_W'(1)) && (|w_exceed);

    // ---------------- solve step decode ----------------
    assign w_az_mag = r_mean[5][31] ? -r_mean[5] : r_mean[5];
    assign w_ha_c   = ((r_step == ST_CHR) || (r_step == ST_SHR)) ? r_cr : r_cp;
    assign w_ha_p   = {1'b0, isa_pkg::Q30_ONE} + sx33(w_ha_c);
    assign w_ha_m   = {1'b0, isa_pkg::Q30_ONE} - sx33(w_ha_c);

    always_comb begin
        w_kind   = K_MUL;
        w_op_a   = '0;
        w_op_b   = '0;
        w_sq_in  = '0;
        w_dv_num = '0;
        w_dv_den = '0;
        unique case (r_step)
            ST_SQ_AX: begin w_op_a = sx35(r_mean[3]); w_op_b = sx33(r_mean[3]); end
            ST_SQ_AY: begin w_op_a = sx35(r_mean[4]); w_op_b = sx33(r_mean[4]); end
            ST_SQ_AZ: begin w_op_a = sx35(r_mean[5]); w_op_b = sx33(r_mean[5]); end
            ST_N1: begin
                w_kind  = K_SQRT;
                w_sq_in = r_sq[1] + r_sq[2];
            end
            ST_N: begin
                w_kind  = K_SQRT;
                w_sq_in = r_sq[0] + r_sq[1] + r_sq[2];
            end
            ST_CR: begin
                w_kind   = K_DIV;
                w_dv_num = {32'b0, w_az_mag} << 30;
                w_dv_den = r_n1;
            end
            ST_CP: begin
                w_kind   = K_DIV;
                w_dv_num = {32'b0, r_n1} << 30;
                w_dv_den = r_n;
            end
            ST_CHR, ST_CHP: begin
                w_kind  = K_SQRT;
                w_sq_in = {31'b0, w_ha_p} << 29;
            end
            ST_SHR, ST_SHP: begin
                w_kind  = K_SQRT;
                w_sq_in = {31'b0, w_ha_m} << 29;
            end
            ST_W:  begin w_op_a = sx35(r_chr);  w_op_b = sx33(r_chp);  end
            ST_X:  begin w_op_a = sx35(r_shr);  w_op_b = sx33(r_chp);  end
            ST_Y:  begin w_op_a = sx35(r_chr);  w_op_b = sx33(r_shp);  end
            ST_Z:  begin w_op_a = sx35(r_shr);  w_op_b = sx33(r_shp);  end
            ST_XZ: begin w_op_a = sx35(r_q[1]); w_op_b = sx33(r_q[3]); end
            ST_WY: begin w_op_a = sx35(r_q[0]); w_op_b = sx33(r_q[2]); end
            ST_YZ: begin w_op_a = sx35(r_q[2]); w_op_b = sx33(r_q[3]); end
            ST_WX: begin w_op_a = sx35(r_q[0]); w_op_b = sx33(r_q[1]); end
            ST_WW: begin w_op_a = sx35(r_q[0]); w_op_b = sx33(r_q[0]); end
            ST_XX: begin w_op_a = sx35(r_q[1]); w_op_b = sx33(r_q[1]); end
            ST_YY: begin w_op_a = sx35(r_q[2]); w_op_b = sx33(r_q[2]); end
            ST_ZZ: begin w_op_a = sx35(r_q[3]); w_op_b = sx33(r_q[3]); end
            ST_GX: begin
                w_op_a = sx35(r_pp[0]) + sx35(r_pp[1]);
                w_op_b = isa_pkg::GRAV2_Q16;
            end
            ST_GY: begin
                w_op_a = sx35(r_pp[2]) - sx35(r_pp[3]);
                w_op_b = isa_pkg::GRAV2_Q16;
            end
            ST_GZ: begin
                w_op_a = sx35(r_pp[4]) - sx35(r_pp[5]) - sx35(r_pp[6]) + sx35(r_pp[7]);
                w_op_b = isa_pkg::GRAV_Q16;
            end
            default: begin
            end
        endcase
    end

    assign w_a_mag = w_op_a[34] ? -w_op_a : w_op_a;
    assign w_b_mag = w_op_b[32] ? -w_op_b : w_op_b;

    // Shift-add multiplier step and digit-by-digit square root step.
    assign w_mul_tmp  = {1'b0, r_prod[66:32]} + (r_prod[0] ? {1'b0, r_mul_a} : 36'd0);
    assign w_mq       = r_mul_neg ? -r_prod[66:30] : r_prod[66:30];
    assign w_rt_sh    = {r_sq_rem, r_sq_in[63:62]};
    assign w_rt_trial = {2'b0, r_sq_root, 2'b01};
    assign w_rt_ge    = w_rt_sh >= w_rt_trial;
    assign w_rt_diff  = w_rt_sh - w_rt_trial;
    assign w_dq       = w_lane_quo[0][31:0];

    // ---------------- control, sums and held results ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= ST_SQ_AX;
            r_cnt     <= '0;
            r_latched <= 1'b0;
            r_count   <= '0;
            r_hq      <= '0;
            r_hb      <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < isa_pkg::NUM_CH; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_latched) begin
                            r_state <= S_OUT;
                        end else begin
                            if (w_cnt_room) begin
                                for (int i = 0; i < isa_pkg::NUM_CH; i++) begin
                                    r_sum[i] <= r_sum[i] + {{CNT_W{s_axis_tdata[32*i+31]}},
                                                            s_axis_tdata[32*i +: 32]};
                                end
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: r_state <= S_DIV;
                S_DIV: begin
                    if (!w_lane_busy[0]) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_step  <= ST_SQ_AX;
                    r_state <= w_moving ? S_OP_START : S_OUT;
                end
                S_OP_START: begin
                    if (r_step == ST_FINAL) begin
                        for (int i = 0; i < 4; i++) begin
                            r_hq[i] <= r_q[i];
                        end
                        for (int i = 0; i < 3; i++) begin
                            r_hb[i]     <= r_mean[i];
                            r_hb[i + 3] <= sat32(sx33(r_mean[i + 3]) - sx33(r_g[i]));
                        end
                        r_latched <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_cnt   <= '1;
                        r_state <= S_OP_WAIT;
                    end
                end
                S_OP_WAIT: begin
                    if (w_kind == K_DIV) begin
                        if (!w_lane_busy[0]) begin
                            r_state <= S_OP_DONE;
                        end
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == '0) begin
                            r_state <= S_OP_DONE;
                        end
                    end
                end
                S_OP_DONE: begin
                    r_step  <= t_step'(r_step + 5'd1);
                    r_state <= S_OP_START;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[0] <= isa_pkg::GYRO_THR_RST;
            r_thr[1] <= isa_pkg::ACCEL_THR_RST;
            r_thr[2] <= isa_pkg::YAW_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                isa_pkg::CFG_GYRO_THR:  r_thr[0] <= i_cfg_data;
                isa_pkg::CFG_ACCEL_THR: r_thr[1] <= i_cfg_data;
                isa_pkg::CFG_YAW_THR:   r_thr[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < isa_pkg::NUM_CH; i++) begin
                r_v[i] <= s_axis_tdata[32*i +: 32];
            end
        end
        if (r_state == S_CHECK) begin
            for (int i = 0; i < isa_pkg::NUM_CH; i++) begin
                r_mean[i] <= w_mean[i];
            end
        end
        if (w_out_load) begin
            r_m_data <= {r_hb, r_hq};
            r_m_user <= r_latched;
        end

        if (w_op_go) begin
            // The sign of z is folded into the product sign.
            r_mul_a   <= w_a_mag;
            r_prod    <= {35'b0, w_b_mag[31:0]};
            r_mul_neg <= w_op_a[34] ^ w_op_b[32] ^ (r_step == ST_Z);
            r_sq_in   <= w_sq_in;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_state == S_OP_WAIT) begin
            if (w_kind == K_MUL) begin
                r_prod <= {w_mul_tmp, r_prod[31:1]};
            end else if (w_kind == K_SQRT) begin
                r_sq_rem  <= w_rt_ge ? w_rt_diff[33:0] : w_rt_sh[33:0];
                r_sq_root <= {r_sq_root[30:0], w_rt_ge};
                r_sq_in   <= {r_sq_in[61:0], 2'b00};
            end
        end

        if (r_state == S_OP_DONE) begin
            case (r_step)
                ST_SQ_AX: r_sq[0] <= r_prod[63:0];
                ST_SQ_AY: r_sq[1] <= r_prod[63:0];
                ST_SQ_AZ: r_sq[2] <= r_prod[63:0];
                ST_N1:    r_n1 <= r_sq_root;
                ST_N:     r_n  <= r_sq_root;
                ST_CR: begin
                    if (r_n1 == '0) begin
                        r_cr <= isa_pkg::Q30_ONE;
                    end else begin
                        r_cr <= r_mean[5][31] ? -w_dq : w_dq;
                    end
                end
                ST_CP:    r_cp  <= (r_n == '0) ? isa_pkg::Q30_ONE : w_dq;
                ST_CHR:   r_chr <= r_sq_root;
                ST_SHR:   r_shr <= r_mean[4][31] ? -r_sq_root : r_sq_root;
                ST_CHP:   r_chp <= r_sq_root;
                ST_SHP: begin
                    if (!r_mean[3][31] && (r_mean[3] != '0)) begin
                        r_shp <= -r_sq_root;
                    end else begin
                        r_shp <= r_sq_root;
                    end
                end
                ST_W:  r_q[0]  <= w_mq[31:0];
                ST_X:  r_q[1]  <= w_mq[31:0];
                ST_Y:  r_q[2]  <= w_mq[31:0];
                ST_Z:  r_q[3]  <= w_mq[31:0];
                ST_XZ: r_pp[0] <= w_mq[31:0];
                ST_WY: r_pp[1] <= w_mq[31:0];
                ST_YZ: r_pp[2] <= w_mq[31:0];
                ST_WX: r_pp[3] <= w_mq[31:0];
                ST_WW: r_pp[4] <= w_mq[31:0];
                ST_XX: r_pp[5] <= w_mq[31:0];
                ST_YY: r_pp[6] <= w_mq[31:0];
                ST_ZZ: r_pp[7] <= w_mq[31:0];
                ST_GX: r_g[0]  <= w_mq[31:0];
                ST_GY: r_g[1]  <= w_mq[31:0];
                ST_GZ: r_g[2]  <= w_mq[31:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- assertions ----------------
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |=> r_latched)
        else $error("motion latch dropped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |=> ($stable(r_hq) && $stable(r_hb)))
        else $error("held results changed after latch");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_busy[0] |-> ((r_state == S_DIV) || (r_state == S_OP_WAIT)))
        else $error("divider busy outside a wait state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_latched && w_cnt_room) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("sample count did not advance");

endmodule
